/* sv/qec_pkg.sv */
// package with shared types and constants of the quadrature edge counter
package qec_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 2;
  localparam int OUT_W           = 32;

  typedef enum logic [1:0] {
    CMD_EDGE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    SCALE_RISE_A    = 2'd0,
    SCALE_RISE_AB   = 2'd1,
    SCALE_ALL_EDGES = 2'd2
  } scale_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIN_MODE = 2'd0,
    REG_SCALE    = 2'd1,
    REG_REVERSE  = 2'd2
  } reg_e;

  typedef struct packed {
    logic   reverse;
    scale_e scale;
  } step_cfg_t;

  typedef struct packed {
    logic up;
    logic down;
  } step_t;

endpackage

/* sv/qec_if.sv */
// request channel interfaces of the quadrature edge counter
interface qec_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       edge_channel;
  logic       level_a;
  logic       level_b;

  modport source (output valid, command, edge_channel, level_a, level_b, input ready);
  modport sink   (input valid, command, edge_channel, level_a, level_b, output ready);
endinterface

interface qec_out_if import qec_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] pulse_count;
  logic signed [OUT_W-1:0] pulse_delta;
  logic                    held_a;
  logic                    held_b;

  modport source (output valid, pulse_count, pulse_delta, held_a, held_b, input ready);
  modport sink   (input valid, pulse_count, pulse_delta, held_a, held_b, output ready);
endinterface

interface qec_cfg_if import qec_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/qec_step.sv */
// quadrature edge decode: direction of one pin change under scale and reversal
module qec_step import qec_pkg::*; (
  input  step_cfg_t cfg_i,
  input  logic      edge_channel_i,
  input  logic      level_a_i,
  input  logic      level_b_i,
  output step_t     step_o
);

  logic main_lvl;
  logic other_lvl;
  logic enabled;
  logic forward;
  logic dir_up;

  assign main_lvl  = edge_channel_i ? level_b_i : level_a_i;
  assign other_lvl = edge_channel_i ? level_a_i : level_b_i;

  always_comb begin
    unique case (cfg_i.scale)
      SCALE_RISE_A:    enabled = !edge_channel_i && main_lvl;
      SCALE_RISE_AB:   enabled = main_lvl;
      SCALE_ALL_EDGES: enabled = 1'b1;
      default:         enabled = 1'b0;
    endcase
  end

  // a rising or b falling: forward when the other pin is high
  assign forward = ((!edge_channel_i) == main_lvl) ? other_lvl : !other_lvl;
  assign dir_up  = forward ^ cfg_i.reverse;

  assign step_o.up   = enabled && dir_up;
  assign step_o.down = enabled && !dir_up;

endmodule

/* sv/quadrature_edge_counter.sv */
// top level of the quadrature edge counter
// Takes one request per clock while input ready is high and returns one result per request,
// registered on acceptance; the counter, the last-read snapshot and the pin latches update in
// the same cycle, so back-to-back pin events each step the counter by at most one. A
// two-entry output buffer keeps input ready high while a single result waits downstream;
// ready drops only when both entries are full. A configuration write takes effect in the
// cycle after it is accepted and clears the counter and the last-read snapshot; a scale
// code of 3 or an index beyond the register list is ignored.
module quadrature_edge_counter import qec_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  qec_cfg_if.sink   cfg_i,
  qec_in_if.sink    in_i,
  qec_out_if.source out_o
);

  typedef struct packed {
    logic signed [OUT_W-1:0] pulse_count;
    logic signed [OUT_W-1:0] pulse_delta;
    logic                    held_a;
    logic                    held_b;
  } result_t;

  logic                   pin_mode_q;
  step_cfg_t              step_cfg_q;
  logic [COUNT_WIDTH-1:0] counter_q, counter_d;
  logic [COUNT_WIDTH-1:0] last_q, last_d;
  logic                   latched_a_q, latched_a_d;
  logic                   latched_b_q, latched_b_d;
  logic [COUNT_WIDTH-1:0] delta;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, result;

  logic  in_fire, cfg_fire, pop, cfg_clear;
  cmd_e  cmd;
  step_t step;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;
  assign in_i.ready  = !skid_valid_q;
  assign in_fire     = in_i.valid && !skid_valid_q;
  assign pop         = out_valid_q && out_o.ready;
  assign cmd         = cmd_e'(in_i.command);

  qec_step u_step (
    .cfg_i          (step_cfg_q),
    .edge_channel_i (in_i.edge_channel),
    .level_a_i      (in_i.level_a),
    .level_b_i      (in_i.level_b),
    .step_o         (step)
  );

  // configuration registers
  always_comb begin
    unique case (reg_e'(cfg_i.index))
      REG_PIN_MODE: cfg_clear = 1'b1;
      REG_SCALE:    cfg_clear = (cfg_i.data != 2'd3);
      REG_REVERSE:  cfg_clear = 1'b1;
      default:      cfg_clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_mode_q         <= 1'b0;
      step_cfg_q.scale   <= SCALE_ALL_EDGES;
      step_cfg_q.reverse <= 1'b0;
    end else if (cfg_fire && cfg_clear) begin
      unique case (reg_e'(cfg_i.index))
        REG_PIN_MODE: pin_mode_q         <= cfg_i.data[0];
        REG_SCALE:    step_cfg_q.scale   <= scale_e'(cfg_i.data);
        REG_REVERSE:  step_cfg_q.reverse <= cfg_i.data[0];
        default:      pin_mode_q         <= pin_mode_q;
      endcase
    end
  end

  // state update for one request
  always_comb begin
    counter_d   = counter_q;
    last_d      = last_q;
    latched_a_d = latched_a_q;
    latched_b_d = latched_b_q;
    delta       = '0;
    unique case (cmd)
      CMD_EDGE: begin
        if (pin_mode_q) begin
          if (in_i.edge_channel) latched_b_d = in_i.level_b;
          else                   latched_a_d = in_i.level_a;
        end else if (step.up) begin
          counter_d = counter_q + COUNT_WIDTH'(1);
        end else if (step.down) begin
          counter_d = counter_q - COUNT_WIDTH'(1);
        end
      end
      CMD_READ: begin
        delta  = counter_q - last_q;
        last_d = counter_q;
      end
      CMD_CLEAR: counter_d = '0;
      default:   counter_d = counter_q;
    endcase
  end

  assign result.pulse_count = OUT_W'(signed'(counter_d));
  assign result.pulse_delta = OUT_W'(signed'(delta));
  assign result.held_a      = latched_a_d;
  assign result.held_b      = latched_b_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q   <= '0;
      last_q      <= '0;
      latched_a_q <= 1'b0;
      latched_b_q <= 1'b0;
    end else if (cfg_fire && cfg_clear) begin
      counter_q <= '0;
      last_q    <= '0;
    end else if (in_fire) begin
      counter_q   <= counter_d;
      last_q      <= last_d;
      latched_a_q <= latched_a_d;
      latched_b_q <= latched_b_d;
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid_q) skid_valid_q <= 1'b0;
      else              out_valid_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (out_valid_q && !pop) skid_q <= result;
      else                     out_q  <= result;
    end else if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pulse_count = out_q.pulse_count;
  assign out_o.pulse_delta = out_q.pulse_delta;
  assign out_o.held_a      = out_q.held_a;
  assign out_o.held_b      = out_q.held_b;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_read_snapshot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd == CMD_READ) |=> (last_q == counter_q))
    else $error("read did not capture the counter");

  a_clear_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd == CMD_CLEAR) |=> (counter_q == '0))
    else $error("clear request left the counter nonzero");

  a_pin_mode_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd == CMD_EDGE && pin_mode_q && !cfg_fire) |=>
      (counter_q == $past(counter_q)))
    else $error("counter moved in plain-input mode");
`endif

endmodule
